// ===== hdl/hsvrgb_pkg.sv =====
// shared widths, constants and types of the hsv to rgb converter
`timescale 1ns / 1ps

package hsvrgb_pkg;

	localparam int HUE_W   = 9;
	localparam int Q_W     = 9;
	localparam int CHAN_W  = 8;
	localparam int GRB_W   = 24;
	localparam int FRAC_W  = 6;
	localparam int SPAN_W  = 14;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [Q_W-1:0]    Q_ONE      = 9'd256;
	localparam logic [HUE_W-1:0]  HUE_FULL   = 9'd360;
	localparam logic [FRAC_W-1:0] SECTOR_DEG = 6'd60;
	localparam logic [SPAN_W-1:0] SPAN_DEN   = 14'd15360;

	localparam logic [Q_W-1:0] SAT_RESET    = 9'd256;
	localparam logic [Q_W-1:0] BRIGHT_RESET = 9'd38;

	// register index, taken from paddr[2]
	localparam logic REG_SATURATION = 1'b0;
	localparam logic REG_BRIGHTNESS = 1'b1;

	typedef enum logic [2:0] {
		SECT_0 = 3'd0,
		SECT_1 = 3'd1,
		SECT_2 = 3'd2,
		SECT_3 = 3'd3,
		SECT_4 = 3'd4,
		SECT_5 = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t           sector;
		logic [FRAC_W-1:0] frac;
		logic              over;
	} hue_dec_t;

endpackage

// ===== hdl/hsv_to_rgb_converter.sv =====
// top level: apb registers and four stage hsv to rgb pipeline
// order: hue decode, span terms, brightness products, then byte mapping, each stage registered
// throughput: one hue per cycle unless out_ready stalls; level math is pipelined
// stalls: out_ready low holds each full stage, bubbles are squeezed out first
// reset: arst_n async active low clears valid bits, saturation to 256, brightness to 38
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsvrgb_pkg::ADDR_W-1:0] paddr,
	input  logic [hsvrgb_pkg::DATA_W-1:0] pwdata,
	output logic [hsvrgb_pkg::DATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hsvrgb_pkg::HUE_W-1:0]  hue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hsvrgb_pkg::CHAN_W-1:0] red,
	output logic [hsvrgb_pkg::CHAN_W-1:0] green,
	output logic [hsvrgb_pkg::CHAN_W-1:0] blue,
	output logic [hsvrgb_pkg::GRB_W-1:0]  grb_word
);
	import hsvrgb_pkg::*;

	// ---------------- configuration registers ----------------
	logic [Q_W-1:0] sat_q;
	logic [Q_W-1:0] bright_q;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q    <= SAT_RESET;
			bright_q <= BRIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SATURATION) begin
				sat_q <= pwdata[Q_W-1:0];
			end else begin
				bright_q <= pwdata[Q_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BRIGHTNESS) begin
			prdata[Q_W-1:0] = bright_q;
		end else begin
			prdata[Q_W-1:0] = sat_q;
		end
	end

	// values above 1.0 saturate to 1.0
	logic [Q_W-1:0] s_eff;
	logic [Q_W-1:0] b_eff;

	assign s_eff = (sat_q > Q_ONE) ? Q_ONE : sat_q;
	assign b_eff = (bright_q > Q_ONE) ? Q_ONE : bright_q;

	// ---------------- stage advance chain ----------------
	// a stage moves when it is empty or the one after it moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: hue decode ----------------
	hue_dec_t dec;

	hsvrgb_sector u_sector (
		.hue (hue),
		.dec (dec)
	);

	sector_t           sector_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic              blank_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			sector_s1 <= dec.sector;
			frac_s1   <= dec.frac;
			// hue past 360 blanks the pixel unless saturation is zero,
			// in which case every level equals full anyway
			blank_s1  <= dec.over && (s_eff != '0);
		end
	end

	// ---------------- stage 2: span terms ----------------
	// tb = 15360 - s*h, tc = 15360 - s*(60-h), ba = b*(256-s)
	logic [SPAN_W-1:0] sh_prod;
	logic [SPAN_W-1:0] shc_prod;
	logic [FRAC_W-1:0] frac_c;
	logic [Q_W-1:0]    s_comp;
	logic [16:0]       ba_prod;

	assign frac_c   = SECTOR_DEG - frac_s1;
	assign sh_prod  = SPAN_W'(s_eff * frac_s1);
	assign shc_prod = SPAN_W'(s_eff * frac_c);
	assign s_comp   = Q_ONE - s_eff;
	assign ba_prod  = 17'(b_eff * s_comp);

	sector_t           sector_s2;
	logic              blank_s2;
	logic [SPAN_W-1:0] tb_s2;
	logic [SPAN_W-1:0] tc_s2;
	logic [16:0]       ba_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			sector_s2 <= sector_s1;
			blank_s2  <= blank_s1;
			tb_s2     <= SPAN_DEN - sh_prod;
			tc_s2     <= SPAN_DEN - shc_prod;
			ba_s2     <= ba_prod;
		end
	end

	// ---------------- stage 3: brightness products ----------------
	// aa = floor(255*b*(256-s) / 65536), full = floor(255*b / 256)
	logic [24:0] aa_wide;
	logic [16:0] full_wide;

	assign aa_wide   = {ba_s2, 8'd0} - {8'd0, ba_s2};
	assign full_wide = {b_eff, 8'd0} - {8'd0, b_eff};

	sector_t            sector_s3;
	logic               blank_s3;
	logic [21:0]        pb_s3;
	logic [21:0]        pc_s3;
	logic [CHAN_W-1:0]  aa_s3;
	logic [CHAN_W-1:0]  full_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			sector_s3 <= sector_s2;
			blank_s3  <= blank_s2;
			pb_s3     <= 22'(b_eff * tb_s2);
			pc_s3     <= 22'(b_eff * tc_s2);
			aa_s3     <= aa_wide[23:16];
			full_s3   <= full_wide[15:8];
		end
	end

	// ---------------- stage 4: byte mapping and sector select ----------------
	// 255/(15360*256) reduces to 17/2^18, so the floor is a shift
	logic [25:0]       bb_wide;
	logic [25:0]       cc_wide;
	logic [CHAN_W-1:0] bb;
	logic [CHAN_W-1:0] cc;
	logic [CHAN_W-1:0] r_n, g_n, b_n;

	assign bb_wide = {pb_s3, 4'd0} + {4'd0, pb_s3};
	assign cc_wide = {pc_s3, 4'd0} + {4'd0, pc_s3};
	assign bb      = bb_wide[25:18];
	assign cc      = cc_wide[25:18];

	always_comb begin
		case (sector_s3)
			SECT_0: begin
				r_n = full_s3; g_n = cc;      b_n = aa_s3;
			end
			SECT_1: begin
				r_n = bb;      g_n = full_s3; b_n = aa_s3;
			end
			SECT_2: begin
				r_n = aa_s3;   g_n = full_s3; b_n = cc;
			end
			SECT_3: begin
				r_n = aa_s3;   g_n = bb;      b_n = full_s3;
			end
			SECT_4: begin
				r_n = cc;      g_n = aa_s3;   b_n = full_s3;
			end
			default: begin
				r_n = full_s3; g_n = aa_s3;   b_n = bb;
			end
		endcase
		if (blank_s3) begin
			r_n = '0;
			g_n = '0;
			b_n = '0;
		end
	end

	logic [CHAN_W-1:0] red_s4, green_s4, blue_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			red_s4   <= r_n;
			green_s4 <= g_n;
			blue_s4  <= b_n;
		end
	end

	assign out_valid = v_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;
	assign grb_word  = {green_s4, red_s4, blue_s4};

endmodule

// ===== hdl/hsvrgb_sector.sv =====
// hue decode into sector, offset within the sector and out-of-range flag
`timescale 1ns / 1ps

module hsvrgb_sector (
	input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
	output hsvrgb_pkg::hue_dec_t         dec
);
	import hsvrgb_pkg::*;

	logic [HUE_W-1:0] hue_n;
	logic [HUE_W-1:0] base;
	logic [HUE_W-1:0] diff;

	assign hue_n = (hue == HUE_FULL) ? '0 : hue;

	always_comb begin
		if (hue_n < 9'd60) begin
			dec.sector = SECT_0;
			base       = 9'd0;
		end else if (hue_n < 9'd120) begin
			dec.sector = SECT_1;
			base       = 9'd60;
		end else if (hue_n < 9'd180) begin
			dec.sector = SECT_2;
			base       = 9'd120;
		end else if (hue_n < 9'd240) begin
			dec.sector = SECT_3;
			base       = 9'd180;
		end else if (hue_n < 9'd300) begin
			dec.sector = SECT_4;
			base       = 9'd240;
		end else begin
			dec.sector = SECT_5;
			base       = 9'd300;
		end
		// offset only meaningful for hue up to 360
		diff     = hue_n - base;
		dec.frac = diff[FRAC_W-1:0];
		dec.over = (hue_n > HUE_FULL);
	end

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the hsv to rgb converter
`timescale 1ns / 1ps

module tb;
	import hsvrgb_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int CHOKE_CYCLES = 400;
	localparam int PHASE_ITEMS  = 154;
	localparam int MAX_REPORTS  = 10;

	// register byte addresses, index times four
	localparam logic [ADDR_W-1:0] SAT_ADDR    = {REG_SATURATION, 2'b00};
	localparam logic [ADDR_W-1:0] BRIGHT_ADDR = {REG_BRIGHTNESS, 2'b00};

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [GRB_W-1:0]  grb;
	} pixel_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [HUE_W-1:0]    hue;
	logic                out_valid;
	logic                out_ready;
	logic [CHAN_W-1:0]   red;
	logic [CHAN_W-1:0]   green;
	logic [CHAN_W-1:0]   blue;
	logic [GRB_W-1:0]    grb_word;

	// hues waiting to be offered, and pixels waiting to come out
	logic [HUE_W-1:0] hue_backlog[$];
	pixel_t           pixel_due[$];

	// shadow copy of the two registers, raw as written
	logic [Q_W-1:0] cfg_sat;
	logic [Q_W-1:0] cfg_bright;

	int unsigned in_mode;
	int unsigned out_mode;
	int unsigned in_gap;
	int unsigned out_hold;
	int unsigned choke_left;
	logic        choke_start;
	int unsigned cycles;
	int unsigned errors;

	hsv_to_rgb_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.hue      (hue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.grb_word (grb_word)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// exact floor(255 * num / (den * 256)), capped at a full byte
	function automatic logic [CHAN_W-1:0] level_byte(input longint num, input longint den);
		longint r;
		r = (255 * num) / (den * 256);
		return (r > 255) ? 8'd255 : r[CHAN_W-1:0];
	endfunction

	// color of one hue under the given register values
	function automatic pixel_t hsv_pixel(input logic [HUE_W-1:0] hue_in,
			input logic [Q_W-1:0] sat_raw, input logic [Q_W-1:0] bri_raw);
		longint s;
		longint b;
		longint hv;
		longint h;
		logic [CHAN_W-1:0] full;
		logic [CHAN_W-1:0] aa;
		logic [CHAN_W-1:0] bb;
		logic [CHAN_W-1:0] cc;
		pixel_t px;
		// registers above 1.0 saturate to 1.0
		s = (sat_raw > Q_ONE) ? longint'(Q_ONE) : longint'(sat_raw);
		b = (bri_raw > Q_ONE) ? longint'(Q_ONE) : longint'(bri_raw);
		hv = (hue_in == HUE_FULL) ? 0 : longint'(hue_in);
		full = level_byte(b, 1);
		px.red = '0;
		px.green = '0;
		px.blue = '0;
		if (s == 0) begin
			// gray: every channel is the brightness byte
			px.red = full;
			px.green = full;
			px.blue = full;
		end else if (hv < longint'(HUE_FULL)) begin
			h = hv % longint'(SECTOR_DEG);
			aa = level_byte(b * (256 - s), 256);
			bb = level_byte(b * (longint'(SPAN_DEN) - s * h), longint'(SPAN_DEN));
			cc = level_byte(b * (longint'(SPAN_DEN) - s * (longint'(SECTOR_DEG) - h)),
				longint'(SPAN_DEN));
			case (sector_t'(hv / longint'(SECTOR_DEG)))
				SECT_0: begin px.red = full; px.green = cc;   px.blue = aa;   end
				SECT_1: begin px.red = bb;   px.green = full; px.blue = aa;   end
				SECT_2: begin px.red = aa;   px.green = full; px.blue = cc;   end
				SECT_3: begin px.red = aa;   px.green = bb;   px.blue = full; end
				SECT_4: begin px.red = cc;   px.green = aa;   px.blue = full; end
				default: begin px.red = full; px.green = aa;  px.blue = bb;   end
			endcase
		end
		// hue past 360 with color present leaves everything black
		px.grb = {px.green, px.red, px.blue};
		return px;
	endfunction

	// per transaction idle draw: none, an occasional random gap, or a random gap drawn every time
	function automatic int unsigned wait_draw(input int unsigned mode);
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
			default: return $urandom_range(0, 17);
		endcase
	endfunction

	function automatic void note_error(input string msg);
		if (errors < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endfunction

	// sender: offers backlog hues, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			hue <= '0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready)
				pixel_due.push_back(hsv_pixel(hue, cfg_sat, cfg_bright));
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (hue_backlog.size() != 0) begin
					hue <= hue_backlog.pop_front();
					in_valid <= 1'b1;
					in_gap = wait_draw(in_mode);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here so the pipe fills and backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			choke_left <= 0;
		end else if (choke_start) begin
			choke_left <= CHOKE_CYCLES;
		end else if (choke_left != 0) begin
			choke_left <= choke_left - 1;
		end
	end

	// receiver: checks each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pixel_due.size() == 0) begin
					note_error($sformatf("unexpected result r=%0d g=%0d b=%0d grb=%06h",
						red, green, blue, grb_word));
				end else begin
					pixel_t want;
					want = pixel_due.pop_front();
					if (red !== want.red)
						note_error($sformatf("red exp %0d got %0d", want.red, red));
					if (green !== want.green)
						note_error($sformatf("green exp %0d got %0d", want.green, green));
					if (blue !== want.blue)
						note_error($sformatf("blue exp %0d got %0d", want.blue, blue));
					if (grb_word !== want.grb)
						note_error($sformatf("grb_word exp %06h got %06h", want.grb, grb_word));
				end
				out_hold = wait_draw(out_mode);
			end else if (out_hold != 0) begin
				out_hold--;
			end
			out_ready <= (out_hold == 0) && (choke_left == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** hsv_to_rgb_converter: FAILED **");
			$finish;
		end
	end

	// apb write: setup then access, register lands on the access edge
	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [Q_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		// upper bits are don't-care for a 9 bit register
		pwdata <= {23'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == SAT_ADDR)
			cfg_sat = value;
		else
			cfg_bright = value;
	endtask

	task automatic set_config(input logic [Q_W-1:0] sat, input logic [Q_W-1:0] bright);
		reg_write(SAT_ADDR, sat);
		reg_write(BRIGHT_ADDR, bright);
	endtask

	// sampled on the falling edge so the queues and valid are settled
	task automatic wait_drained();
		@(negedge clk);
		while (hue_backlog.size() != 0 || in_valid || pixel_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_hues(input int unsigned count);
		for (int i = 0; i < count; i++) begin
			// mostly legal hues, some past 360
			if ($urandom_range(0, 9) == 0)
				hue_backlog.push_back(HUE_W'($urandom_range(361, 511)));
			else
				hue_backlog.push_back(HUE_W'($urandom_range(0, 360)));
		end
	endtask

	function automatic logic [Q_W-1:0] pick_q();
		case ($urandom_range(0, 5))
			0: return 9'd0;
			1: return 9'd256;
			2: return Q_W'($urandom_range(257, 511));
			default: return Q_W'($urandom_range(0, 256));
		endcase
	endfunction

	initial begin
		logic [HUE_W-1:0] sweep[$];
		logic [Q_W-1:0] sat_list[4];
		logic [Q_W-1:0] bright_list[4];
		cycles = 0;
		errors = 0;
		cfg_sat = SAT_RESET;
		cfg_bright = BRIGHT_RESET;
		in_mode = 0;
		out_mode = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		choke_start <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: sector edges, 360 wrap, out of range hues, all-ones and all-zeros
		sweep = '{9'd0, 9'd1, 9'd30, 9'd59, 9'd60, 9'd119, 9'd120, 9'd180,
			9'd240, 9'd300, 9'd359, 9'd360, 9'd361, 9'd511};
		foreach (sweep[i])
			hue_backlog.push_back(sweep[i]);
		wait_drained();

		// gray: zero saturation ignores hue, even past 360
		set_config(9'd0, 9'd256);
		sweep = '{9'd0, 9'd200, 9'd360, 9'd511};
		foreach (sweep[i])
			hue_backlog.push_back(sweep[i]);
		wait_drained();

		// registers above 1.0 saturate
		set_config(9'd511, 9'd511);
		sweep = '{9'd45, 9'd170, 9'd290, 9'd400};
		foreach (sweep[i])
			hue_backlog.push_back(sweep[i]);
		wait_drained();

		sat_list = '{9'd256, 9'd1, 9'd257, 9'd128};
		bright_list = '{9'd0, 9'd256, 9'd300, 9'd255};

		// random phases, idling styles cycle through every pairing
		for (int ph = 0; ph < 12; ph++) begin
			if (ph < 4)
				set_config(sat_list[ph], bright_list[ph]);
			else
				set_config(pick_q(), pick_q());
			in_mode = (ph == 3) ? 0 : ph % 3;
			out_mode = (ph / 3) % 3;
			@(negedge clk);
			queue_hues(PHASE_ITEMS);
			if (ph == 3) begin
				// hold the output off while hues keep coming
				@(posedge clk);
				choke_start <= 1'b1;
				@(posedge clk);
				choke_start <= 1'b0;
			end
			wait_drained();
		end

		// let any stray result show up
		repeat (12) @(posedge clk);
		if (errors == 0 && pixel_due.size() == 0) begin
			$display("** hsv_to_rgb_converter: PASSED **");
		end else begin
			$display("** hsv_to_rgb_converter: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_sector.sv
hdl/hsv_to_rgb_converter.sv
bench/tb.sv
